// ----- hdl/rcfd_pkg.sv -----
// Shared types and constants for the serial radio-control frame decoder.
// No dependencies; every other file of the block refers to this package.
package rcfd_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int CHANNEL_WIDTH = 11;
    localparam int FRAME_BYTES   = 25;
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int INDEX_W       = $clog2(CHANNEL_COUNT);
    localparam int POS_W         = $clog2(FRAME_BYTES);
    localparam int BITSEL_W      = $clog2(PAYLOAD_W);

    // Byte positions inside a frame; the header sits at position zero.
    localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(PAYLOAD_BYTES);
    localparam logic [POS_W-1:0] POS_FLAG    = POS_W'(PAYLOAD_BYTES + 1);

    // Flag byte bit positions.
    localparam int FLAG_D1_BIT       = 0;
    localparam int FLAG_D2_BIT       = 1;
    localparam int FLAG_LOST_BIT     = 2;
    localparam int FLAG_FAILSAFE_BIT = 3;

    // Link status codes.
    localparam logic [1:0] LINK_OK       = 2'd0;
    localparam logic [1:0] LINK_LOST     = 2'd1;
    localparam logic [1:0] LINK_FAILSAFE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HEADER_BYTE = 2'd0;
    localparam logic [1:0] CFG_END_BYTE    = 2'd1;
    localparam logic [1:0] CFG_HOLD_ENABLE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] HEADER_RESET = 8'h0F;
    localparam logic [7:0] END_RESET    = 8'h00;
    localparam logic       HOLD_RESET   = 1'b1;

    // One accepted frame, as handed from the parser to the channel emitter.
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 digital_one;
        logic                 digital_two;
        logic [1:0]           link_status;
        logic                 value_held;
    } t_job;

endpackage

// ----- hdl/rcfd_front.sv -----
// Frame parser: hunts for the header, collects payload and flag bytes and
// pushes a complete, checked frame into the job queue. Depends on rcfd_pkg.
module rcfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_header_byte,
    input  logic [7:0]        i_end_byte,
    input  logic              i_hold_enable,
    output logic              o_push,
    output rcfd_pkg::t_job    o_job
);

    logic                              r_in_frame;
    logic [rcfd_pkg::POS_W-1:0]        r_pos;
    logic [rcfd_pkg::PAYLOAD_W-1:0]    r_payload;
    logic [7:0]                        r_flag;
    logic                              r_push;
    rcfd_pkg::t_job                    r_job;
    logic [1:0]                        w_status;

    // Link status from the stored flag byte; failsafe wins over lost.
    always_comb begin
        if (r_flag[rcfd_pkg::FLAG_FAILSAFE_BIT]) begin
            w_status = rcfd_pkg::LINK_FAILSAFE;
        end else if (r_flag[rcfd_pkg::FLAG_LOST_BIT]) begin
            w_status = rcfd_pkg::LINK_LOST;
        end else begin
            w_status = rcfd_pkg::LINK_OK;
        end
    end

    // Frame state: position counter and hunt flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_push     <= 1'b0;
        end else begin
            r_push <= 1'b0;
            if (i_accept) begin
                if (!r_in_frame) begin
                    if (i_rx_byte == i_header_byte) begin
                        r_in_frame <= 1'b1;
                        r_pos      <= rcfd_pkg::POS_FIRST;
                    end
                end else if (r_pos <= rcfd_pkg::POS_PAYLOAD) begin
                    r_pos <= r_pos + 1'b1;
                end else if (r_pos == rcfd_pkg::POS_FLAG) begin
                    r_pos <= r_pos + 1'b1;
                end else begin
                    r_in_frame <= 1'b0;
                    r_pos      <= '0;
                    r_push     <= (i_rx_byte == i_end_byte);
                end
            end
        end
    end

    // Frame data. Payload bytes shift in from the top so that the first
    // payload byte ends up in the lowest bits.
    always_ff @(posedge i_clk) begin
        if (i_accept && r_in_frame) begin
            if (r_pos <= rcfd_pkg::POS_PAYLOAD) begin
                r_payload <= {i_rx_byte, r_payload[rcfd_pkg::PAYLOAD_W-1:8]};
            end else if (r_pos == rcfd_pkg::POS_FLAG) begin
                r_flag <= i_rx_byte;
            end else begin
                r_job.payload     <= r_payload;
                r_job.digital_one <= r_flag[rcfd_pkg::FLAG_D1_BIT];
                r_job.digital_two <= r_flag[rcfd_pkg::FLAG_D2_BIT];
                r_job.link_status <= w_status;
                r_job.value_held  <= (w_status != rcfd_pkg::LINK_OK) && i_hold_enable;
            end
        end
    end

    assign o_push = r_push;
    assign o_job  = r_job;

endmodule

// ----- hdl/rcfd_queue.sv -----
// Two-entry queue of decoded frames between the parser and the emitter.
// Depends on rcfd_pkg for the frame record type.
module rcfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcfd_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output rcfd_pkg::t_job o_job
);

    rcfd_pkg::t_job r_entry [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_job   = r_entry[r_rd_ptr];

endmodule

// ----- hdl/rcfd_back.sv -----
// Channel emitter: walks the 16 channels of the queued frame, one per
// cycle while the output is not stalled, keeps the last good values and
// drives the result register. Depends on rcfd_pkg.
module rcfd_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_job_valid,
    input  rcfd_pkg::t_job                         i_job,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [rcfd_pkg::INDEX_W-1:0]           o_channel_index,
    output logic [rcfd_pkg::CHANNEL_WIDTH-1:0]     o_channel_value,
    output logic                                   o_digital_one,
    output logic                                   o_digital_two,
    output logic [1:0]                             o_link_status,
    output logic                                   o_value_held,
    output logic                                   o_last
);

    localparam logic [rcfd_pkg::INDEX_W-1:0] LAST_CH =
        rcfd_pkg::INDEX_W'(rcfd_pkg::CHANNEL_COUNT - 1);

    logic [rcfd_pkg::INDEX_W-1:0]       r_ch;
    logic [rcfd_pkg::CHANNEL_WIDTH-1:0] r_held [rcfd_pkg::CHANNEL_COUNT];
    logic                               r_out_valid;
    logic [rcfd_pkg::INDEX_W-1:0]       r_channel_index;
    logic [rcfd_pkg::CHANNEL_WIDTH-1:0] r_channel_value;
    logic                               r_digital_one;
    logic                               r_digital_two;
    logic [1:0]                         r_link_status;
    logic                               r_value_held;
    logic                               r_last;
    logic                               w_load;
    logic [rcfd_pkg::BITSEL_W-1:0]      w_bit_base;
    logic [rcfd_pkg::CHANNEL_WIDTH-1:0] w_decoded;

    // A result is loaded whenever the output register is free or moving on.
    assign w_load = i_job_valid && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_load && (r_ch == LAST_CH);

    // Channel field select from the payload.
    assign w_bit_base = rcfd_pkg::BITSEL_W'(r_ch) *
                        rcfd_pkg::BITSEL_W'(rcfd_pkg::CHANNEL_WIDTH);
    assign w_decoded  = i_job.payload[w_bit_base +: rcfd_pkg::CHANNEL_WIDTH];

    // Channel counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= i_job_valid;
            end
            if (w_load) begin
                r_ch <= (r_ch == LAST_CH) ? '0 : r_ch + 1'b1;
            end
        end
    end

    // Last good values, updated by frames whose link status is OK.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rcfd_pkg::CHANNEL_COUNT; i++) begin
                r_held[i] <= '0;
            end
        end else if (w_load && (i_job.link_status == rcfd_pkg::LINK_OK)) begin
            r_held[r_ch] <= w_decoded;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_channel_index <= r_ch;
            r_channel_value <= i_job.value_held ? r_held[r_ch] : w_decoded;
            r_digital_one   <= i_job.digital_one;
            r_digital_two   <= i_job.digital_two;
            r_link_status   <= i_job.link_status;
            r_value_held    <= i_job.value_held;
            r_last          <= (r_ch == LAST_CH);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_channel_index;
    assign o_channel_value = r_channel_value;
    assign o_digital_one   = r_digital_one;
    assign o_digital_two   = r_digital_two;
    assign o_link_status   = r_link_status;
    assign o_value_held    = r_value_held;
    assign o_last          = r_last;

endmodule

// ----- hdl/rc_serial_frame_channel_decoder_core.sv -----
// Top level of the serial radio-control frame decoder: configuration
// registers, frame parser, job queue and channel emitter.
// Depends on rcfd_pkg, rcfd_front, rcfd_queue and rcfd_back.
//
// Usage: received serial bytes enter on the input channel (i_in_valid,
// o_in_stall, i_rx_byte), one transfer per byte. The parser hunts for the
// header byte, then collects 22 payload bytes, a flag byte and the end
// byte. When the end byte matches, the frame goes into a two-entry queue
// and the emitter produces 16 channel results on the output channel
// (o_out_valid, i_out_stall), channel 0 first, o_last set on channel 15.
// A frame with a bad end byte produces nothing and hunting resumes.
// Throughput: one byte per cycle on the input while the queue is not full;
// one result per cycle on the output while the receiver does not stall.
// A frame passes through the parser's job register and a queue entry, and
// its first result through the output register, after the end byte.
// The input is stalled only while the queue holds two frames; a stalling
// receiver holds the output register and, through the queue, eventually
// the input. Reset (synchronous, active low) restores the register
// defaults, returns the parser to hunting, empties the queue and clears
// the held channel values to zero.
module rc_serial_frame_channel_decoder_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [1:0]                             i_cfg_index,
    input  logic [7:0]                             i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [7:0]                             i_rx_byte,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [rcfd_pkg::INDEX_W-1:0]           o_channel_index,
    output logic [rcfd_pkg::CHANNEL_WIDTH-1:0]     o_channel_value,
    output logic                                   o_digital_one,
    output logic                                   o_digital_two,
    output logic [1:0]                             o_link_status,
    output logic                                   o_value_held,
    output logic                                   o_last
);

    logic [7:0]     r_header_byte;
    logic [7:0]     r_end_byte;
    logic           r_hold_enable;
    logic           w_in_accept;
    logic           w_push;
    logic           w_pop;
    logic           w_q_valid;
    logic           w_q_full;
    rcfd_pkg::t_job w_front_job;
    rcfd_pkg::t_job w_head_job;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= rcfd_pkg::HEADER_RESET;
            r_end_byte    <= rcfd_pkg::END_RESET;
            r_hold_enable <= rcfd_pkg::HOLD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rcfd_pkg::CFG_HEADER_BYTE: r_header_byte <= i_cfg_data;
                rcfd_pkg::CFG_END_BYTE:    r_end_byte    <= i_cfg_data;
                rcfd_pkg::CFG_HOLD_ENABLE: r_hold_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input transfer; held off only while the queue is full.
    assign o_in_stall  = w_q_full;
    assign w_in_accept = i_in_valid && !w_q_full;

    rcfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_rx_byte     (i_rx_byte),
        .i_header_byte (r_header_byte),
        .i_end_byte    (r_end_byte),
        .i_hold_enable (r_hold_enable),
        .o_push        (w_push),
        .o_job         (w_front_job)
    );

    rcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_job   (w_head_job)
    );

    rcfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (w_q_valid),
        .i_job           (w_head_job),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_digital_one   (o_digital_one),
        .o_digital_two   (o_digital_two),
        .o_link_status   (o_link_status),
        .o_value_held    (o_value_held),
        .o_last          (o_last)
    );

endmodule

// ----- dv/rc_serial_frame_channel_decoder_core_tb.sv -----
// Testbench for the serial radio-control frame decoder core.
// Depends on rcfd_pkg and rc_serial_frame_channel_decoder_core; a scoreboard
// class predicts the 16 channel results of each good frame from the byte stream.
`timescale 1ns / 1ps

module rc_serial_frame_channel_decoder_core_tb;

    // The configuration port has one index past the register list.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [rcfd_pkg::INDEX_W-1:0]       index;
        logic [rcfd_pkg::CHANNEL_WIDTH-1:0] value;
        logic                               digital_one;
        logic                               digital_two;
        logic [1:0]                         link_status;
        logic                               value_held;
        logic                               last;
    } t_channel_result;

    // Tracks the frame parser, the held channels and the registers, and
    // keeps the channel results still owed by the block.
    class frame_scoreboard;
        logic [7:0]                         header_reg;
        logic [7:0]                         end_reg;
        logic                               hold_reg;
        bit                                 in_frame;
        int                                 position;
        logic [rcfd_pkg::PAYLOAD_W-1:0]     payload;
        logic [7:0]                         flags;
        logic [rcfd_pkg::CHANNEL_WIDTH-1:0] held [rcfd_pkg::CHANNEL_COUNT];
        t_channel_result                    expected_channels [$];
        int                                 errors;

        function new();
            header_reg = rcfd_pkg::HEADER_RESET;
            end_reg    = rcfd_pkg::END_RESET;
            hold_reg   = rcfd_pkg::HOLD_RESET;
            in_frame   = 1'b0;
            position   = 0;
            payload    = '0;
            flags      = '0;
            errors     = 0;
            foreach (held[c]) held[c] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                rcfd_pkg::CFG_HEADER_BYTE: header_reg = data;
                rcfd_pkg::CFG_END_BYTE:    end_reg = data;
                rcfd_pkg::CFG_HOLD_ENABLE: hold_reg = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_channels.size();
        endfunction

        // Advances the parser by one transferred byte; a matching end byte
        // queues the results of the whole frame.
        function void note_byte(logic [7:0] rx);
            logic [1:0]                         link;
            logic                               use_held;
            logic [rcfd_pkg::CHANNEL_WIDTH-1:0] decoded;
            t_channel_result                    res;
            if (!in_frame) begin
                if (rx == header_reg) begin
                    in_frame = 1'b1;
                    position = 1;
                end
                return;
            end
            if (position >= 1 && position <= rcfd_pkg::PAYLOAD_BYTES) begin
                payload[(position - 1) * 8 +: 8] = rx;
                position++;
                return;
            end
            if (position == rcfd_pkg::PAYLOAD_BYTES + 1) begin
                flags = rx;
                position++;
                return;
            end
            in_frame = 1'b0;
            position = 0;
            if (rx != end_reg)
                return;

            // Failsafe takes precedence over a lost signal.
            link = rcfd_pkg::LINK_OK;
            if (flags[rcfd_pkg::FLAG_LOST_BIT])
                link = rcfd_pkg::LINK_LOST;
            if (flags[rcfd_pkg::FLAG_FAILSAFE_BIT])
                link = rcfd_pkg::LINK_FAILSAFE;
            use_held = (link != rcfd_pkg::LINK_OK) && hold_reg;
            for (int c = 0; c < rcfd_pkg::CHANNEL_COUNT; c++) begin
                decoded = payload[c * rcfd_pkg::CHANNEL_WIDTH +: rcfd_pkg::CHANNEL_WIDTH];
                if (link == rcfd_pkg::LINK_OK)
                    held[c] = decoded;
                res.index       = rcfd_pkg::INDEX_W'(c);
                res.value       = use_held ? held[c] : decoded;
                res.digital_one = flags[rcfd_pkg::FLAG_D1_BIT];
                res.digital_two = flags[rcfd_pkg::FLAG_D2_BIT];
                res.link_status = link;
                res.value_held  = use_held;
                res.last        = (c == rcfd_pkg::CHANNEL_COUNT - 1);
                expected_channels.push_back(res);
            end
        endfunction

        function void check_channel(t_channel_result got);
            t_channel_result want;
            if (expected_channels.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result: ch %0d value %0d", $time,
                             got.index, got.value);
                return;
            end
            want = expected_channels.pop_front();
            if (got.index !== want.index || got.value !== want.value ||
                got.digital_one !== want.digital_one ||
                got.digital_two !== want.digital_two ||
                got.link_status !== want.link_status ||
                got.value_held !== want.value_held || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display({"%0t: mismatch, expected ch %0d val %0d d1 %b d2 %b",
                              " link %0d held %b last %b"},
                             $time, want.index, want.value, want.digital_one,
                             want.digital_two, want.link_status, want.value_held,
                             want.last);
                    $display({"%0t:             actual ch %0d val %0d d1 %b d2 %b",
                              " link %0d held %b last %b"},
                             $time, got.index, got.value, got.digital_one,
                             got.digital_two, got.link_status, got.value_held,
                             got.last);
                end
            end
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_wr_en = 1'b0;
    logic [1:0]                         i_cfg_index = rcfd_pkg::CFG_HEADER_BYTE;
    logic [7:0]                         i_cfg_data = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic [7:0]                         i_rx_byte = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [rcfd_pkg::INDEX_W-1:0]       o_channel_index;
    logic [rcfd_pkg::CHANNEL_WIDTH-1:0] o_channel_value;
    logic                               o_digital_one;
    logic                               o_digital_two;
    logic [1:0]                         o_link_status;
    logic                               o_value_held;
    logic                               o_last;

    frame_scoreboard sb = new();

    // Sender pacing and receiver hold-off requests.
    bit   steady_sender = 1'b0;
    int   burst_left = 0;
    int   hold_ticket = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   rx_mode = 0;
    int   rx_count = 0;
    int   idle_cycles = 0;

    rc_serial_frame_channel_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_digital_one   (o_digital_one),
        .o_digital_two   (o_digital_two),
        .o_link_status   (o_link_status),
        .o_value_held    (o_value_held),
        .o_last          (o_last)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stall pattern: a randomly redrawn mode picks the stall behaviour,
    // and a hold-off request overrides it for a long stretch.
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = LONG_HOLD_CYCLES;
        end
        rx_count++;
        if (rx_count % 50 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                2: i_out_stall <= rx_count[0];
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Output monitor and watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        t_channel_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.index       = o_channel_index;
            got.value       = o_channel_value;
            got.digital_one = o_digital_one;
            got.digital_two = o_digital_two;
            got.link_status = o_link_status;
            got.value_held  = o_value_held;
            got.last        = o_last;
            sb.check_channel(got);
        end
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one byte and waits for its transfer, then applies burst pacing unless steady_sender is set.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_byte(b);
        if (steady_sender)
            return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 30);
        gap = $urandom_range(1, 6);
        i_in_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] hdr,
                              input logic [rcfd_pkg::PAYLOAD_W-1:0] pl,
                              input logic [7:0] flg, input logic [7:0] tail);
        send_byte(hdr);
        for (int i = 0; i < rcfd_pkg::PAYLOAD_BYTES; i++)
            send_byte(pl[i * 8 +: 8]);
        send_byte(flg);
        send_byte(tail);
    endtask

    // Stops sending and waits until every owed result has arrived.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_wr_en <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [rcfd_pkg::PAYLOAD_W-1:0] rand_payload();
        logic [191:0] w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return w[rcfd_pkg::PAYLOAD_W-1:0];
    endfunction

    // Main stimulus sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values: a bad end byte, with header values inside
        // the frame that must not restart it, then a stray byte.
        send_frame(8'h0F, {rcfd_pkg::PAYLOAD_BYTES{8'h0F}}, 8'h0F, 8'h5A);
        send_byte(8'h33);
        settle();

        // Holding off through a wide write, high extremes, ignored index;
        // a lost link then reports the decoded values.
        write_reg(rcfd_pkg::CFG_HOLD_ENABLE, 8'hFE);
        write_reg(rcfd_pkg::CFG_HEADER_BYTE, 8'hFF);
        write_reg(rcfd_pkg::CFG_END_BYTE, 8'hFF);
        write_reg(CFG_UNUSED, 8'hA5);
        send_frame(8'hFF, rand_payload(), 8'h05, 8'hFF);
        settle();

        // Low extremes, holding back on through a wide write. The receiver
        // holds off while two frames and a few idle bytes arrive back to
        // back, so the queue fills and the input stalls. The good frame
        // refreshes the held values; the next one has both lost and
        // failsafe set and reports the held values.
        write_reg(rcfd_pkg::CFG_HEADER_BYTE, 8'h00);
        write_reg(rcfd_pkg::CFG_END_BYTE, 8'h00);
        write_reg(rcfd_pkg::CFG_HOLD_ENABLE, 8'h03);
        hold_ticket <= hold_ticket + 1;
        steady_sender = 1'b1;
        send_frame(8'h00, rand_payload(), 8'h02, 8'h00);
        send_frame(8'h00, rand_payload(), 8'h0C, 8'h00);
        repeat (4) send_byte(8'h55);
        steady_sender = 1'b0;
        settle();

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
